// ===== design/acmf_pkg.sv =====
package acmf_pkg;

    localparam int WINDOW_DEFAULT   = 8;
    localparam int SAMPLE_W         = 12;
    localparam int IN_W             = 16;
    localparam int RATIO_W          = 12;
    localparam int PROD_W           = SAMPLE_W + RATIO_W;
    localparam int Q8_SHIFT         = 8;
    localparam int MEDIAN_MIN_COUNT = 4;
    localparam int APB_DATA_W       = 32;
    localparam int APB_ADDR_W       = 3;

    localparam logic [SAMPLE_W-1:0]   SAMPLE_MAX  = 12'hFFF;
    localparam logic [RATIO_W-1:0]    RATIO_RESET = 12'd64;
    localparam logic [APB_ADDR_W-1:0] ADDR_RATIO  = 3'd0;

endpackage

// ===== design/acmf_ram.sv =====
module acmf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/adc_mean_median_switch_filter_unit.sv =====
// ADC mean/median switch filter.
// Input channel: i_sample with i_in_valid / o_in_ready. A request is taken at a
// rising edge where both are high, and the sample is clamped to 4095.
// Output channel: o_filtered, o_average and o_median_chosen with o_out_valid /
// i_out_ready. The result sits in an output register until it is taken.
// The ratio register sits at APB address 0; pready is always high and writes
// take effect at the access cycle. Writes are expected only while idle.
// Each request runs through a window update step, then a restoring divider
// that resolves one quotient bit per cycle, then, once at least four samples
// are held, a median search that reuses one pair of comparators over the
// single read port of the window memory. Up to count median candidates are
// tried, each loaded and then compared against every held sample, then the
// ratio test (multiply, then compare) runs and the result is handed off.
// o_in_ready is high only while the block is idle. A stalled receiver blocks the
// next result from leaving, and the block then holds in its final step.
// Reset clears the window state, the running sum and the output valid, and
// sets the ratio to 64; no clearing pass is needed.
module adc_mean_median_switch_filter_unit #(
    parameter int WINDOW = acmf_pkg::WINDOW_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [acmf_pkg::IN_W-1:0]           i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [acmf_pkg::SAMPLE_W-1:0]       o_filtered,
    output logic [acmf_pkg::SAMPLE_W-1:0]       o_average,
    output logic                                o_median_chosen,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [acmf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [acmf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [acmf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import acmf_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_OLD   = 10'b00_0000_0010,
        S_DIV   = 10'b00_0000_0100,
        S_CAND  = 10'b00_0000_1000,
        S_CLOAD = 10'b00_0001_0000,
        S_SWEEP = 10'b00_0010_0000,
        S_CHECK = 10'b00_0100_0000,
        S_MUL   = 10'b00_1000_0000,
        S_CMP   = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [RATIO_W-1:0]    r_ratio;
    logic [SAMPLE_W-1:0]   r_samp;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [IDX_W-1:0]      r_slot, n_slot;
    logic                  r_full, n_full;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [SUM_W-1:0]      r_quo, n_quo;
    logic [CNT_W-1:0]      r_rem, n_rem;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [IDX_W-1:0]      r_ci, n_ci;
    logic [CNT_W-1:0]      r_cj, n_cj;
    logic [CNT_W-1:0]      r_lt, n_lt;
    logic [CNT_W-1:0]      r_le, n_le;
    logic                  r_pv, n_pv;
    logic [SAMPLE_W-1:0]   r_cv, n_cv;
    logic [SAMPLE_W-1:0]   r_diff, n_diff;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic                  r_pick, n_pick;
    logic                  r_ovalid, n_ovalid;
    logic [SAMPLE_W-1:0]   r_ofilt, n_ofilt;
    logic [SAMPLE_W-1:0]   r_oavg, n_oavg;
    logic                  r_oflag, n_oflag;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_raddr;
    logic [SAMPLE_W-1:0]   ram_rdata;
    logic [CNT_W:0]        rem_sh;
    logic [SAMPLE_W-1:0]   avg;
    logic [CNT_W-1:0]      half;
    logic                  in_acc;
    logic                  cfg_wr;

    acmf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW),
        .ADDR_W(IDX_W)
    ) u_window (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_slot),
        .i_wdata(r_samp),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign in_acc = i_in_valid && o_in_ready;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_RATIO);
    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign avg    = (r_quo > SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX : r_quo[SAMPLE_W-1:0];
    assign half   = r_count >> 1;

    always_comb begin
        n_state  = r_state;
        n_sum    = r_sum;
        n_slot   = r_slot;
        n_full   = r_full;
        n_count  = r_count;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_step   = r_step;
        n_ci     = r_ci;
        n_cj     = r_cj;
        n_lt     = r_lt;
        n_le     = r_le;
        n_pv     = r_pv;
        n_cv     = r_cv;
        n_diff   = r_diff;
        n_prod   = r_prod;
        n_pick   = r_pick;
        n_ovalid = r_ovalid && !i_out_ready;
        n_ofilt  = r_ofilt;
        n_oavg   = r_oavg;
        n_oflag  = r_oflag;
        ram_we   = 1'b0;
        ram_raddr = r_slot;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_OLD;
                end
            end
            S_OLD: begin
                ram_we = 1'b1;
                n_sum  = r_sum - (r_full ? SUM_W'(ram_rdata) : '0) + SUM_W'(r_samp);
                if (32'(r_slot) == WINDOW - 1) begin
                    n_slot  = '0;
                    n_full  = 1'b1;
                    n_count = CNT_W'(WINDOW);
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_count = r_full ? CNT_W'(WINDOW) : CNT_W'(r_slot) + 1'b1;
                end
                n_quo   = n_sum;
                n_rem   = '0;
                n_step  = STEP_W'(SUM_W - 1);
                n_pick  = 1'b0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (rem_sh >= {1'b0, r_count}) begin
                    n_rem = CNT_W'(rem_sh - {1'b0, r_count});
                    n_quo = {r_quo[SUM_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[CNT_W-1:0];
                    n_quo = {r_quo[SUM_W-2:0], 1'b0};
                end
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_ci = '0;
                    if (32'(r_count) >= MEDIAN_MIN_COUNT) begin
                        n_state = S_CAND;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CAND: begin
                ram_raddr = r_ci;
                n_state   = S_CLOAD;
            end
            S_CLOAD: begin
                n_cv    = ram_rdata;
                n_cj    = '0;
                n_lt    = '0;
                n_le    = '0;
                n_pv    = 1'b0;
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                if (r_pv) begin
                    if (ram_rdata < r_cv) begin
                        n_lt = r_lt + 1'b1;
                    end
                    if (ram_rdata <= r_cv) begin
                        n_le = r_le + 1'b1;
                    end
                end
                if (r_cj != r_count) begin
                    ram_raddr = r_cj[IDX_W-1:0];
                    n_cj      = r_cj + 1'b1;
                    n_pv      = 1'b1;
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if ((r_lt <= half) && (half < r_le)) begin
                    n_state = S_MUL;
                end else begin
                    n_ci    = r_ci + 1'b1;
                    n_state = S_CAND;
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(avg) * PROD_W'(r_ratio);
                n_diff  = (avg > r_cv) ? (avg - r_cv) : (r_cv - avg);
                n_state = S_CMP;
            end
            S_CMP: begin
                n_pick  = (PROD_W'({r_diff, {Q8_SHIFT{1'b0}}}) > r_prod);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_ofilt  = r_pick ? r_cv : avg;
                    n_oavg   = avg;
                    n_oflag  = r_pick;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ratio  <= RATIO_RESET;
            r_sum    <= '0;
            r_slot   <= '0;
            r_full   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sum    <= n_sum;
            r_slot   <= n_slot;
            r_full   <= n_full;
            r_ovalid <= n_ovalid;
            if (cfg_wr) begin
                r_ratio <= pwdata[RATIO_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_samp <= (i_sample > IN_W'(SAMPLE_MAX)) ? SAMPLE_MAX : i_sample[SAMPLE_W-1:0];
        end
        r_count <= n_count;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_step  <= n_step;
        r_ci    <= n_ci;
        r_cj    <= n_cj;
        r_lt    <= n_lt;
        r_le    <= n_le;
        r_pv    <= n_pv;
        r_cv    <= n_cv;
        r_diff  <= n_diff;
        r_prod  <= n_prod;
        r_pick  <= n_pick;
        r_ofilt <= n_ofilt;
        r_oavg  <= n_oavg;
        r_oflag <= n_oflag;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_ovalid;
    assign o_filtered      = r_ofilt;
    assign o_average       = r_oavg;
    assign o_median_chosen = r_oflag;
    assign pready          = 1'b1;
    assign prdata          = (paddr == ADDR_RATIO) ? APB_DATA_W'(r_ratio) : '0;

endmodule

// ===== design/acmf_checker.sv =====
module acmf_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic [acmf_pkg::IN_W-1:0]           i_sample,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [acmf_pkg::SAMPLE_W-1:0]       o_filtered,
    input logic [acmf_pkg::SAMPLE_W-1:0]       o_average,
    input logic                                o_median_chosen,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [acmf_pkg::APB_ADDR_W-1:0]     paddr,
    input logic [acmf_pkg::APB_DATA_W-1:0]     pwdata,
    input logic [acmf_pkg::APB_DATA_W-1:0]     prdata,
    input logic                                pready
);
    import acmf_pkg::*;

    logic cfg_wr;
    logic in_acc;

    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_RATIO);
    assign in_acc = i_in_valid && o_in_ready && (i_sample == i_sample);

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input side still ready right after a request");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_filtered)
            && $stable(o_average) && $stable(o_median_chosen))
        else $error("stalled result changed or dropped");

    a_average_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_median_chosen |-> o_filtered == o_average)
        else $error("average chosen but filtered differs from average");

    a_median_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_median_chosen |-> o_filtered != o_average)
        else $error("median chosen although it equals the average");

    a_ratio_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (paddr != ADDR_RATIO)
            || (prdata == APB_DATA_W'($past(pwdata[RATIO_W-1:0]))))
        else $error("ratio register does not read back the written value");

endmodule

bind adc_mean_median_switch_filter_unit acmf_checker u_acmf_checker (.*);

// ===== sim/adc_mean_median_switch_filter_unit_tb.sv =====
`timescale 1ns / 1ps

module adc_mean_median_switch_filter_unit_tb;

    import acmf_pkg::*;

    localparam int WIN_DEPTH = WINDOW_DEFAULT;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int PHASE_SETTLE_CYCLES = 8;
    localparam int END_SETTLE_CYCLES = 150;
    localparam int MAX_REPORTS = 10;
    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

    localparam logic [IN_W-1:0] DIRECTED_SAMPLES [22] = '{
        16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0000, 16'hFFFF, 16'h1000, 16'h0FFF,
        16'h8000, 16'h7FFF, 16'h0064, 16'h0064, 16'h0064, 16'h0064, 16'h0064, 16'h0BB8,
        16'h0064, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h0001
    };

    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered;
        logic [SAMPLE_W-1:0] average;
        logic                median_chosen;
    } t_filter_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [IN_W-1:0]       i_sample;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [SAMPLE_W-1:0]   o_filtered;
    logic [SAMPLE_W-1:0]   o_average;
    logic                  o_median_chosen;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    t_filter_result pending_filter_results[$];

    logic [SAMPLE_W-1:0] window_model [WIN_DEPTH];
    int                  window_sum;
    int                  write_slot_model;
    bit                  window_full_model;
    logic [RATIO_W-1:0]  ratio_model;
    int                  sample_level;

    int error_count;
    bit tx_steady;
    bit rx_steady;
    int hold_off_requests;
    int hold_off_served;
    int stall_left;

    adc_mean_median_switch_filter_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_filtered     (o_filtered),
        .o_average      (o_average),
        .o_median_chosen(o_median_chosen),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] window_median_of(input int count);
        int below;
        int not_above;
        logic [SAMPLE_W-1:0] median;
        median = '0;
        for (int i = 0; i < count; i++) begin
            below = 0;
            not_above = 0;
            for (int j = 0; j < count; j++) begin
                if (window_model[j] < window_model[i]) begin
                    below++;
                end
                if (window_model[j] <= window_model[i]) begin
                    not_above++;
                end
            end
            if (below <= count / 2 && count / 2 < not_above) begin
                median = window_model[i];
            end
        end
        return median;
    endfunction

    function automatic t_filter_result predict_filter(input logic [IN_W-1:0] raw);
        logic [SAMPLE_W-1:0] clamped;
        logic [SAMPLE_W-1:0] median;
        int count;
        int avg;
        int diff;
        t_filter_result res;
        clamped = (raw > IN_W'(SAMPLE_MAX)) ? SAMPLE_MAX : raw[SAMPLE_W-1:0];
        if (window_full_model) begin
            window_sum -= int'(window_model[write_slot_model]);
        end
        window_model[write_slot_model] = clamped;
        window_sum += int'(clamped);
        if (write_slot_model == WIN_DEPTH - 1) begin
            write_slot_model = 0;
            window_full_model = 1'b1;
        end else begin
            write_slot_model++;
        end
        count = window_full_model ? WIN_DEPTH : write_slot_model;
        avg = window_sum / count;
        res.average = avg[SAMPLE_W-1:0];
        res.filtered = avg[SAMPLE_W-1:0];
        res.median_chosen = 1'b0;
        if (count >= MEDIAN_MIN_COUNT) begin
            median = window_median_of(count);
            diff = (avg > int'(median)) ? avg - int'(median) : int'(median) - avg;
            if (diff * 256 > avg * int'(ratio_model)) begin
                res.filtered = median;
                res.median_chosen = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic [IN_W-1:0] random_sample();
        int pick;
        int value;
        pick = $urandom_range(99);
        if ($urandom_range(19) == 0) begin
            sample_level = $urandom_range(4095);
        end
        if (pick < 50) begin
            value = sample_level + int'($urandom_range(40)) - 20;
            if (value < 0) begin
                value = 0;
            end else if (value > 4095) begin
                value = 4095;
            end
        end else if (pick < 65) begin
            value = $urandom_range(4095);
        end else if (pick < 77) begin
            value = $urandom_range(65535);
        end else if (pick < 88) begin
            value = $urandom_range(3);
        end else begin
            value = $urandom_range(4200, 4080);
        end
        return value[IN_W-1:0];
    endfunction

    function automatic int pick_gap(input bit steady);
        int pick;
        pick = $urandom_range(99);
        if (steady || pick < 70) begin
            return 0;
        end else if (pick < 95) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(50, 10);
    endfunction

    task automatic send_sample(input logic [IN_W-1:0] value);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample <= value;
        do @(posedge i_clk); while (!o_in_ready);
        pending_filter_results.push_back(predict_filter(value));
    endtask

    task automatic finish_phase();
        i_in_valid <= 1'b0;
        while (pending_filter_results.size() != 0) @(posedge i_clk);
        repeat (PHASE_SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_ratio_readback();
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_RATIO;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(ratio_model)) begin
            note_failure($sformatf("ratio readback: expected %0d, got %0d", ratio_model, prdata));
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_ratio(input logic [RATIO_W-1:0] value);
        apb_write(ADDR_RATIO, APB_DATA_W'(value));
        ratio_model = value;
        check_ratio_readback();
    endtask

    task automatic test_directed_samples();
        check_ratio_readback();
        foreach (DIRECTED_SAMPLES[i]) begin
            send_sample(DIRECTED_SAMPLES[i]);
        end
        finish_phase();
    endtask

    task automatic test_ratio_register();
        set_ratio('0);
        apb_write(ADDR_UNUSED, 32'h0000_0123);
        check_ratio_readback();
        set_ratio(12'hFFF);
        set_ratio(12'd256);
        repeat (20) send_sample(random_sample());
        finish_phase();
    endtask

    task automatic test_input_backpressure();
        tx_steady = 1'b1;
        hold_off_requests++;
        repeat (40) send_sample(random_sample());
        finish_phase();
        tx_steady = 1'b0;
    endtask

    task automatic test_random_stream();
        logic [RATIO_W-1:0] ratio;
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: begin
                    ratio = 12'hFFF;
                end
                1: begin
                    ratio = '0;
                end
                2: begin
                    ratio = RATIO_RESET;
                end
                default: begin
                    ratio = $urandom_range(1) ? $urandom_range(4095) : $urandom_range(300);
                end
            endcase
            set_ratio(ratio);
            tx_steady = (phase == 3);
            rx_steady = (phase == 3 || phase == 6);
            repeat (90) send_sample(random_sample());
            finish_phase();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else if (hold_off_served != hold_off_requests) begin
            hold_off_served = hold_off_requests;
            stall_left = HOLD_OFF_CYCLES;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (rx_steady || $urandom_range(99) >= 15) begin
            i_out_ready <= 1'b1;
        end else begin
            stall_left = ($urandom_range(9) == 0) ? $urandom_range(59, 19) : $urandom_range(2);
            i_out_ready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_filter_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_filter_results.size() == 0) begin
                note_failure($sformatf("unexpected result: filtered %0d average %0d median %0b",
                                       o_filtered, o_average, o_median_chosen));
            end else begin
                want = pending_filter_results.pop_front();
                if (o_filtered !== want.filtered || o_average !== want.average ||
                    o_median_chosen !== want.median_chosen) begin
                    note_failure($sformatf({"result mismatch: expected filtered %0d average %0d ",
                                            "median %0b, got filtered %0d average %0d median %0b"},
                                           want.filtered, want.average, want.median_chosen,
                                           o_filtered, o_average, o_median_chosen));
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_sample <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        error_count = 0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        hold_off_requests = 0;
        hold_off_served = 0;
        window_sum = 0;
        write_slot_model = 0;
        window_full_model = 1'b0;
        ratio_model = RATIO_RESET;
        sample_level = 2048;
        foreach (window_model[i]) begin
            window_model[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_samples();
        test_ratio_register();
        test_input_backpressure();
        test_random_stream();

        repeat (END_SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_filter_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/acmf_pkg.sv
design/acmf_ram.sv
design/adc_mean_median_switch_filter_unit.sv
design/acmf_checker.sv
sim/adc_mean_median_switch_filter_unit_tb.sv
